// ----- hdl/txin_pkg.sv -----
`default_nettype none

package txin_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int CONS_W      = 17;
    localparam int VALUE_W     = 64;
    localparam int POS_W       = 16;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    localparam logic [CONS_W-1:0] CONS_MAX = {CONS_W{1'b1}};
    localparam logic [15:0] MAX_SCRIPT_RESET = 16'd10000;

    localparam logic [2:0] PH_HASH       = 3'd0;
    localparam logic [2:0] PH_INDEX      = 3'd1;
    localparam logic [2:0] PH_LEN_PREFIX = 3'd2;
    localparam logic [2:0] PH_LEN_EXT    = 3'd3;
    localparam logic [2:0] PH_SCRIPT     = 3'd4;
    localparam logic [2:0] PH_SEQ        = 3'd5;

    localparam logic [2:0] EV_HASH   = 3'd0;
    localparam logic [2:0] EV_INDEX  = 3'd1;
    localparam logic [2:0] EV_LENGTH = 3'd2;
    localparam logic [2:0] EV_SCRIPT = 3'd3;
    localparam logic [2:0] EV_DONE   = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_INCOMPLETE = 2'd1;
    localparam logic [1:0] ERR_OVERSIZE   = 2'd2;

    localparam logic [7:0] CS_PREFIX_2 = 8'hFD;
    localparam logic [7:0] CS_PREFIX_4 = 8'hFE;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [VALUE_W-1:0] field_value;
        logic [POS_W-1:0]   byte_position;
        logic [1:0]         error_code;
        logic [CONS_W-1:0]  bytes_consumed;
        logic               last_of_run;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/txin_ifs.sv -----
`default_nettype none

interface txin_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, data_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface txin_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_script_bytes;

    modport source (output valid, max_script_bytes, input ready);
    modport sink   (input valid, max_script_bytes, output ready);
endinterface

interface txin_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [63:0] field_value;
    logic [15:0] byte_position;
    logic [1:0]  error_code;
    logic [16:0] bytes_consumed;
    logic        last_of_run;

    modport source (output valid, event_kind, field_value, byte_position, error_code,
                    bytes_consumed, last_of_run, input ready);
    modport sink   (input valid, event_kind, field_value, byte_position, error_code,
                    bytes_consumed, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- hdl/tx_input_record_parser_top.sv -----
`default_nettype none

// Channel   Role   Beat carries
// i_in      sink   data_byte, final_byte
// i_cfg     sink   max_script_bytes (always ready)
// o_out     source event_kind, field_value, byte_position, error_code,
//                  bytes_consumed, last_of_run
//
// An accepted byte is registered, parsed in the next cycle and its zero, one or
// two results enter an eight-entry output queue, so a byte can be taken every cycle
// while input ready is high. A byte's results pass the input register and output queue;
// a byte with two results occupies the output for two beats, so the drain sets the rate.
// Input ready drops while three or fewer queue entries are free.
// Reset is synchronous and active low; it restores the limit of 10000 and the hash phase.

module tx_input_record_parser_top import txin_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    txin_in_if.sink     i_in,
    txin_cfg_if.sink    i_cfg,
    txin_out_if.source  o_out
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_fin;
    logic [15:0]        r_max_script;

    logic [1:0]         w_res_cnt;
    t_result [1:0]      w_res;
    t_result            w_head;
    logic [CNT_W-1:0]   w_count;

    assign i_in.ready  = (w_count <= CNT_W'(FIFO_DEPTH - 4));
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_max_script <= MAX_SCRIPT_RESET;
        end else begin
            r_in_valid <= i_in.valid && i_in.ready;
            if (i_cfg.valid) begin
                r_max_script <= i_cfg.max_script_bytes;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_fin  <= i_in.final_byte;
        end
    end

    txin_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_byte       (r_in_byte),
        .i_final      (r_in_fin),
        .i_max_script (r_max_script),
        .o_res_cnt    (w_res_cnt),
        .o_res        (w_res)
    );

    txin_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (w_res_cnt),
        .i_push_data (w_res),
        .i_pop       (o_out.ready),
        .o_head      (w_head),
        .o_count     (w_count)
    );

    assign o_out.valid          = (w_count != '0);
    assign o_out.event_kind     = w_head.event_kind;
    assign o_out.field_value    = w_head.field_value;
    assign o_out.byte_position  = w_head.byte_position;
    assign o_out.error_code     = w_head.error_code;
    assign o_out.bytes_consumed = w_head.bytes_consumed;
    assign o_out.last_of_run    = w_head.last_of_run;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(FIFO_DEPTH))
        else $error("Output queue overflow.");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.event_kind == EV_ERROR |-> o_out.error_code != ERR_NONE)
        else $error("Error beat without an error code.");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.event_kind == EV_DONE |-> o_out.last_of_run)
        else $error("Done beat is not the last of its run.");

    a_accept_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_in_valid)
        else $error("Accepted byte was not parsed.");
`endif

endmodule

`default_nettype wire

// ----- hdl/txin_core.sv -----
`default_nettype none

module txin_core import txin_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [7:0]             i_byte,
    input  wire logic                   i_final,
    input  wire logic [15:0]            i_max_script,
    output logic      [1:0]             o_res_cnt,
    output t_result   [1:0]             o_res
);

    logic [2:0]             r_phase, n_phase;
    logic [15:0]            r_fc, n_fc;
    logic [VALUE_W-1:0]     r_acc, n_acc;
    logic [3:0]             r_vleft, n_vleft;
    logic [LENGTH_BITS-1:0] r_slen, n_slen;
    logic [CONS_W-1:0]      r_cons, n_cons;

    logic [CONS_W-1:0]      w_cons_inc;
    logic [15:0]            w_fc_inc;
    logic [VALUE_W-1:0]     w_acc_or;

    assign w_cons_inc = (r_cons != CONS_MAX) ? r_cons + 1'b1 : r_cons;
    assign w_fc_inc   = r_fc + 16'd1;
    assign w_acc_or   = r_acc | ({56'd0, i_byte} << {r_fc[2:0], 3'b000});

    always_comb begin
        logic               ended;
        logic               do_len;
        logic [VALUE_W-1:0] len_val;
        logic [1:0]         cnt;
        t_result [1:0]      res;

        n_phase = r_phase;
        n_fc    = r_fc;
        n_acc   = r_acc;
        n_vleft = r_vleft;
        n_slen  = r_slen;
        n_cons  = w_cons_inc;
        ended   = 1'b0;
        do_len  = 1'b0;
        len_val = '0;
        cnt     = 2'd0;
        res     = '0;

        case (r_phase)
            PH_HASH: begin
                res[0].event_kind    = EV_HASH;
                res[0].field_value   = {56'd0, i_byte};
                res[0].byte_position = {11'd0, 5'd31 - r_fc[4:0]};
                cnt = 2'd1;
                n_fc = w_fc_inc;
                if (w_fc_inc >= 16'd32) begin
                    n_phase = PH_INDEX;
                    n_fc    = '0;
                    n_acc   = '0;
                end
            end
            PH_INDEX, PH_SEQ: begin
                n_acc = w_acc_or;
                n_fc  = w_fc_inc;
                if (w_fc_inc >= 16'd4) begin
                    res[0].field_value = {32'd0, w_acc_or[31:0]};
                    cnt = 2'd1;
                    n_fc  = '0;
                    n_acc = '0;
                    if (r_phase == PH_INDEX) begin
                        res[0].event_kind = EV_INDEX;
                        n_phase = PH_LEN_PREFIX;
                    end else begin
                        res[0].event_kind     = EV_DONE;
                        res[0].bytes_consumed = w_cons_inc;
                        n_phase = PH_HASH;
                        n_vleft = '0;
                        n_slen  = '0;
                        n_cons  = '0;
                        ended   = 1'b1;
                    end
                end
            end
            PH_LEN_PREFIX: begin
                if (i_byte < CS_PREFIX_2) begin
                    do_len  = 1'b1;
                    len_val = {56'd0, i_byte};
                end else begin
                    if (i_byte == CS_PREFIX_2) begin
                        n_vleft = 4'd2;
                    end else if (i_byte == CS_PREFIX_4) begin
                        n_vleft = 4'd4;
                    end else begin
                        n_vleft = 4'd8;
                    end
                    n_acc   = '0;
                    n_fc    = '0;
                    n_phase = PH_LEN_EXT;
                end
            end
            PH_LEN_EXT: begin
                n_acc = w_acc_or;
                n_fc  = w_fc_inc;
                if (r_vleft <= 4'd1) begin
                    n_vleft = '0;
                    do_len  = 1'b1;
                    len_val = w_acc_or;
                end else begin
                    n_vleft = r_vleft - 4'd1;
                end
            end
            PH_SCRIPT: begin
                res[0].event_kind    = EV_SCRIPT;
                res[0].field_value   = {56'd0, i_byte};
                res[0].byte_position = r_fc;
                cnt = 2'd1;
                n_fc = w_fc_inc;
                if (w_fc_inc >= r_slen) begin
                    n_phase = PH_SEQ;
                    n_fc    = '0;
                    n_acc   = '0;
                end
            end
            default: begin
                n_phase = PH_HASH;
                n_fc    = '0;
                n_acc   = '0;
                n_vleft = '0;
                n_slen  = '0;
                n_cons  = '0;
                ended   = 1'b1;
            end
        endcase

        if (do_len) begin
            cnt = 2'd1;
            res[0].field_value = len_val;
            if (len_val > {48'd0, i_max_script} || (|len_val[VALUE_W-1:LENGTH_BITS])) begin
                res[0].event_kind     = EV_ERROR;
                res[0].error_code     = ERR_OVERSIZE;
                res[0].bytes_consumed = w_cons_inc;
                n_phase = PH_HASH;
                n_fc    = '0;
                n_acc   = '0;
                n_vleft = '0;
                n_slen  = '0;
                n_cons  = '0;
                ended   = 1'b1;
            end else begin
                res[0].event_kind = EV_LENGTH;
                n_slen  = len_val[LENGTH_BITS-1:0];
                n_fc    = '0;
                n_acc   = '0;
                n_phase = (len_val != '0) ? PH_SCRIPT : PH_SEQ;
            end
        end

        if (i_final && !ended) begin
            res[cnt[0]].event_kind     = EV_ERROR;
            res[cnt[0]].field_value    = '0;
            res[cnt[0]].byte_position  = '0;
            res[cnt[0]].error_code     = ERR_INCOMPLETE;
            res[cnt[0]].bytes_consumed = w_cons_inc;
            cnt = cnt + 2'd1;
            n_phase = PH_HASH;
            n_fc    = '0;
            n_acc   = '0;
            n_vleft = '0;
            n_slen  = '0;
            n_cons  = '0;
        end

        if (cnt == 2'd1) begin
            res[0].last_of_run = 1'b1;
        end else if (cnt == 2'd2) begin
            res[1].last_of_run = 1'b1;
        end

        o_res_cnt = i_valid ? cnt : 2'd0;
        o_res     = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HASH;
            r_fc    <= '0;
            r_acc   <= '0;
            r_vleft <= '0;
            r_slen  <= '0;
            r_cons  <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_fc    <= n_fc;
            r_acc   <= n_acc;
            r_vleft <= n_vleft;
            r_slen  <= n_slen;
            r_cons  <= n_cons;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/txin_fifo.sv -----
`default_nettype none

module txin_fifo import txin_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic    [1:0]       i_push_cnt,
    input  wire t_result [1:0]       i_push_data,
    input  wire logic                i_pop,
    output t_result                  o_head,
    output logic         [CNT_W-1:0] o_count
);

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wp, r_rp;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   w_wp1;
    logic               w_pop;

    assign w_wp1   = r_wp + 1'b1;
    assign w_pop   = i_pop && (r_count != '0);
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_push_data[0];
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wp1] <= i_push_data[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PTR_W'(i_push_cnt);
            r_rp    <= r_rp + PTR_W'(w_pop);
            r_count <= r_count + CNT_W'(i_push_cnt) - CNT_W'(w_pop);
        end
    end

endmodule

`default_nettype wire

// ----- tb/tx_input_record_parser_top_tb.sv -----
`default_nettype none

module tx_input_record_parser_top_tb;
    import txin_pkg::*;

    localparam logic [7:0] CS_PREFIX_8 = 8'hFF;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int RUN_LIMIT = 8 * 400000;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } byte_beat_t;

    logic i_clk;
    logic i_rst_n;

    txin_in_if  in_if();
    txin_cfg_if cfg_if();
    txin_out_if out_if();

    tx_input_record_parser_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    byte_beat_t pending_bytes[$];
    t_result    expected_events[$];
    byte_beat_t next_beat;
    t_result    want;

    int bytes_queued = 0;
    int bytes_taken = 0;
    int mismatch_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    logic quiet_mode = 1'b0;
    logic hold_armed = 1'b0;
    logic out_hold = 1'b0;

    // Parser state as the block should hold it.
    logic [2:0]  ps_phase;
    logic [15:0] ps_count;
    logic [63:0] ps_acc;
    logic [3:0]  ps_left;
    logic [15:0] ps_len;
    logic [16:0] ps_consumed;
    logic [15:0] script_limit;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void restart_parser();
        ps_phase = PH_HASH;
        ps_count = '0;
        ps_acc = '0;
        ps_left = '0;
        ps_len = '0;
        ps_consumed = '0;
    endfunction

    function automatic void add_event(input logic [2:0] kind, input logic [63:0] value,
                                      input logic [15:0] pos, input logic [1:0] err,
                                      input logic [16:0] cons);
        t_result ev;
        ev.event_kind = kind;
        ev.field_value = value;
        ev.byte_position = pos;
        ev.error_code = err;
        ev.bytes_consumed = cons;
        ev.last_of_run = 1'b0;
        expected_events.push_back(ev);
    endfunction

    // Returns 1 when the length is rejected and the record ends here.
    function automatic logic finish_length(input logic [63:0] value);
        if (value > {48'b0, script_limit} || value > ((64'd1 << LENGTH_BITS) - 64'd1)) begin
            add_event(EV_ERROR, value, '0, ERR_OVERSIZE, ps_consumed);
            restart_parser();
            return 1'b1;
        end
        add_event(EV_LENGTH, value, '0, ERR_NONE, '0);
        ps_len = value[15:0];
        ps_count = '0;
        ps_acc = '0;
        ps_phase = (value != 0) ? PH_SCRIPT : PH_SEQ;
        return 1'b0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        int   prior_count;
        logic ended;
        prior_count = expected_events.size();
        ended = 1'b0;
        if (ps_consumed != CONS_MAX)
            ps_consumed = ps_consumed + 1'b1;
        case (ps_phase)
            PH_HASH: begin
                add_event(EV_HASH, {56'b0, b}, {11'b0, 5'd31 - ps_count[4:0]}, ERR_NONE, '0);
                ps_count = ps_count + 1'b1;
                if (ps_count >= 32) begin
                    ps_phase = PH_INDEX;
                    ps_count = '0;
                    ps_acc = '0;
                end
            end
            PH_INDEX, PH_SEQ: begin
                ps_acc = ps_acc | ({56'b0, b} << (8 * ps_count[2:0]));
                ps_count = ps_count + 1'b1;
                if (ps_count >= 4) begin
                    if (ps_phase == PH_INDEX) begin
                        add_event(EV_INDEX, {32'b0, ps_acc[31:0]}, '0, ERR_NONE, '0);
                        ps_phase = PH_LEN_PREFIX;
                        ps_count = '0;
                        ps_acc = '0;
                    end else begin
                        add_event(EV_DONE, {32'b0, ps_acc[31:0]}, '0, ERR_NONE, ps_consumed);
                        restart_parser();
                        ended = 1'b1;
                    end
                end
            end
            PH_LEN_PREFIX: begin
                if (b < CS_PREFIX_2) begin
                    ended = finish_length({56'b0, b});
                end else begin
                    ps_left = (b == CS_PREFIX_2) ? 4'd2 : (b == CS_PREFIX_4) ? 4'd4 : 4'd8;
                    ps_acc = '0;
                    ps_count = '0;
                    ps_phase = PH_LEN_EXT;
                end
            end
            PH_LEN_EXT: begin
                ps_acc = ps_acc | ({56'b0, b} << (8 * ps_count[2:0]));
                ps_count = ps_count + 1'b1;
                if (ps_left <= 1) begin
                    ps_left = '0;
                    ended = finish_length(ps_acc);
                end else begin
                    ps_left = ps_left - 1'b1;
                end
            end
            PH_SCRIPT: begin
                add_event(EV_SCRIPT, {56'b0, b}, ps_count, ERR_NONE, '0);
                ps_count = ps_count + 1'b1;
                if (ps_count >= ps_len) begin
                    ps_phase = PH_SEQ;
                    ps_count = '0;
                    ps_acc = '0;
                end
            end
            default: begin
                restart_parser();
                ended = 1'b1;
            end
        endcase
        if (fin && !ended) begin
            add_event(EV_ERROR, '0, '0, ERR_INCOMPLETE, ps_consumed);
            restart_parser();
        end
        if (expected_events.size() > prior_count)
            expected_events[expected_events.size() - 1].last_of_run = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data_byte <= '0;
            in_if.final_byte <= 1'b0;
            restart_parser();
            script_limit = MAX_SCRIPT_RESET;
            send_gap = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                parse_byte(in_if.data_byte, in_if.final_byte);
                bytes_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    next_beat = pending_bytes.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.data_byte <= next_beat.data;
                    in_if.final_byte <= next_beat.fin;
                    if (!quiet_mode && $urandom_range(0, 11) == 0)
                        send_gap = $urandom_range(1, 8);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_events.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat: kind %0d value %h pos %0d",
                                 out_if.event_kind, out_if.field_value, out_if.byte_position,
                                 " err %0d cons %0d last %0d",
                                 out_if.error_code, out_if.bytes_consumed, out_if.last_of_run);
                end else begin
                    want = expected_events.pop_front();
                    if (want.event_kind !== out_if.event_kind ||
                        want.field_value !== out_if.field_value ||
                        want.byte_position !== out_if.byte_position ||
                        want.error_code !== out_if.error_code ||
                        want.bytes_consumed !== out_if.bytes_consumed ||
                        want.last_of_run !== out_if.last_of_run) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected kind %0d value %h pos %0d",
                                     want.event_kind, want.field_value, want.byte_position,
                                     " err %0d cons %0d last %0d",
                                     want.error_code, want.bytes_consumed, want.last_of_run);
                            $display("          actual   kind %0d value %h pos %0d",
                                     out_if.event_kind, out_if.field_value,
                                     out_if.byte_position,
                                     " err %0d cons %0d last %0d",
                                     out_if.error_code, out_if.bytes_consumed,
                                     out_if.last_of_run);
                        end
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_if.ready <= 1'b0;
            end else if (out_hold) begin
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!quiet_mode && $urandom_range(0, 9) == 0)
                    recv_gap = $urandom_range(1, 8);
            end
        end
    end

    // The receiver stops for a long stretch so that the output queue fills and input ready drops.
    initial begin
        wait (hold_armed);
        @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    function automatic logic [7:0] pick_byte(input int fill);
        return (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
    endfunction

    // A cut of -1 sends the whole record, -2 ends it early at a random byte.
    task automatic queue_record(input logic [63:0] len, input int enc, input int cut_at,
                                input bit fin_last, input int fill);
        logic [7:0] rec[$];
        byte_beat_t beat;
        int         nbytes;
        int         stop;
        repeat (36) rec.push_back(pick_byte(fill));
        nbytes = (enc == 0) ? 0 : (enc == 1) ? 2 : (enc == 2) ? 4 : 8;
        case (enc)
            0: rec.push_back(len[7:0]);
            1: rec.push_back(CS_PREFIX_2);
            2: rec.push_back(CS_PREFIX_4);
            default: rec.push_back(CS_PREFIX_8);
        endcase
        for (int i = 0; i < nbytes; i++)
            rec.push_back(len[8*i +: 8]);
        if (len <= {48'b0, script_limit} && len <= 64'hFFFF) begin
            for (int i = 0; i < len + 4 && (cut_at < 0 || rec.size() <= cut_at); i++)
                rec.push_back(pick_byte(fill));
        end
        if (cut_at == -2)
            stop = $urandom_range(0, rec.size() - 2);
        else if (cut_at >= 0)
            stop = cut_at;
        else
            stop = rec.size() - 1;
        for (int i = 0; i <= stop; i++) begin
            beat.data = rec[i];
            beat.fin = (i == stop) && (cut_at != -1 || fin_last);
            pending_bytes.push_back(beat);
        end
        bytes_queued += stop + 1;
    endtask

    task automatic queue_noise(input int count);
        byte_beat_t beat;
        for (int i = 0; i < count; i++) begin
            beat.data = 8'($urandom_range(0, 255));
            beat.fin = (i == count - 1) || ($urandom_range(0, 15) == 0);
            pending_bytes.push_back(beat);
        end
        bytes_queued += count;
    endtask

    task automatic random_record();
        logic [63:0] len;
        int          enc;
        int          min_enc;
        int          k;
        k = $urandom_range(0, 9);
        if (k < 6)
            len = 64'($urandom_range(0, 20));
        else if (k < 8)
            len = 64'($urandom_range(21, 80));
        else if (k == 8)
            len = {48'b0, script_limit} + 64'($urandom_range(1, 50));
        else
            len = ({$urandom, $urandom} >> $urandom_range(0, 47)) | 64'h1_0000;
        min_enc = (len < CS_PREFIX_2) ? 0 : (len <= 64'hFFFF) ? 1 :
                  (len <= 64'hFFFF_FFFF) ? 2 : 3;
        enc = ($urandom_range(0, 3) == 0) ? $urandom_range(min_enc, 3) : min_enc;
        k = $urandom_range(0, 99);
        if (k < 70)
            queue_record(len, enc, -1, 1'($urandom_range(0, 1)), -1);
        else if (k < 85)
            queue_record(len, enc, -2, 1'b0, -1);
        else
            queue_noise($urandom_range(1, 30));
    endtask

    task automatic random_bytes(input int budget);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < budget)
            random_record();
    endtask

    task automatic settle();
        while (bytes_taken != bytes_queued || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.max_script_bytes <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        script_limit = value;
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.final_byte = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.max_script_bytes = '0;
        out_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Record layout: hash 0-31, index 32-35, length prefix 36, then extension,
        // script and sequence bytes.
        queue_record(64'd3, 0, -1, 1'b0, 8'hFF);
        queue_record(64'd0, 0, -1, 1'b1, 8'h00);
        queue_record(64'd5, 0, 0, 1'b0, -1);
        queue_record(64'd1, 0, 33, 1'b0, -1);
        queue_record(64'd2, 1, -1, 1'b0, -1);
        queue_record(64'd300, 2, 38, 1'b0, -1);
        queue_record(64'd0, 3, -1, 1'b0, -1);
        queue_record(64'hFC, 0, 36, 1'b0, -1);
        queue_record(64'd1, 0, 39, 1'b0, -1);
        queue_record(64'd10000, 1, 45, 1'b0, -1);
        queue_record(64'd10001, 1, -1, 1'b1, -1);
        queue_record(64'hFFFF_FFFF_FFFF_FFFF, 3, -1, 1'b0, -1);
        settle();

        write_limit(16'd0);
        queue_record(64'd0, 0, -1, 1'b0, -1);
        queue_record(64'd1, 0, -1, 1'b0, -1);
        random_bytes(110);
        settle();

        write_limit(16'hFFFF);
        queue_record(64'hFFFF, 1, 45, 1'b0, -1);
        queue_record(64'h1_0000, 2, -1, 1'b0, -1);
        random_bytes(250);
        hold_armed = 1'b1;
        settle();

        write_limit(16'($urandom_range(1, 100)));
        random_bytes(200);
        settle();

        write_limit(16'($urandom_range(0, 65535)));
        quiet_mode = 1'b1;
        random_bytes(200);
        settle();

        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
